FILE: rtl/euler_planar_field_integrator_defines.svh
// assertion macros shared by the integrator modules
// no dependencies; taken in by `include where assertions are written
`ifndef EULER_PLANAR_FIELD_INTEGRATOR_DEFINES_SVH
`define EULER_PLANAR_FIELD_INTEGRATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define EPFI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epfi: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define EPFI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epfi: next-cycle check failed");

`endif

FILE: rtl/epfi_pkg.sv
// shared types, codes and micro-op sequences of the planar field integrator
// no dependencies
package epfi_pkg;

    localparam int OPD_W      = 64;
    localparam int HALF_W     = 32;
    localparam int PP_W       = 2 * HALF_W;
    localparam int ACC_W      = 2 * OPD_W;
    localparam int MAG_W      = 61;
    localparam int COEF_W     = 32;
    localparam int COEF_N     = 6;
    localparam int STEP_W     = 31;
    localparam int PT_W       = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int UOP_IDX_W  = 4;

    // product magnitude limit
    localparam logic [MAG_W-1:0] LIM_MAG = {1'b1, {(MAG_W-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF4 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF5 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF6 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 4'd7;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic signed [COEF_W-1:0] COEF_RESET [COEF_N] = '{
        32'sd16777216, 32'sd16777216, 32'sd3355443,
        32'sd16777216, 32'sd16777216, 32'sd3355443
    };
    localparam logic [STEP_W-1:0] STEP_RESET = 31'd10066;

    typedef enum logic [1:0] {
        FM_LINEAR   = 2'd0,
        FM_AFFINE   = 2'd1,
        FM_BILINEAR = 2'd2,
        FM_NONE     = 2'd3
    } field_mode_t;

    typedef enum logic [2:0] {
        OPA_X, OPA_Y, OPA_XY, OPA_DX, OPA_DY
    } opa_t;

    typedef enum logic [2:0] {
        OPB_COEF1, OPB_COEF2, OPB_COEF3, OPB_COEF4,
        OPB_COEF5, OPB_COEF6, OPB_STEP, OPB_Y
    } opb_t;

    typedef enum logic [2:0] {
        DST_XY, DST_DX_ADD, DST_DX_SUB, DST_DY_ADD, DST_DY_SUB, DST_POS_X, DST_POS_Y
    } dst_t;

    typedef struct packed {
        opa_t a_sel;
        opb_t b_sel;
        dst_t dst;
    } uop_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic init;
        logic mul_start;
        logic commit;
        logic out_load;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        field_mode_t mode;
        logic        mul_done;
    } sts_t;

    typedef enum logic [2:0] {
        CS_IDLE, CS_INIT, CS_ISSUE, CS_WAIT, CS_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MS_IDLE, MS_RUN, MS_LAST
    } mul_state_t;

    localparam logic [UOP_IDX_W-1:0] UOPS_LINEAR   = 4'd6;
    localparam logic [UOP_IDX_W-1:0] UOPS_AFFINE   = 4'd6;
    localparam logic [UOP_IDX_W-1:0] UOPS_BILINEAR = 4'd9;
    localparam logic [UOP_IDX_W-1:0] UOPS_NONE     = 4'd2;

    function automatic uop_t mk_uop(input opa_t a, input opb_t b, input dst_t d);
        uop_t u;
        u.a_sel = a;
        u.b_sel = b;
        u.dst   = d;
        return u;
    endfunction

    function automatic logic [UOP_IDX_W-1:0] uop_count(input field_mode_t mode);
        logic [UOP_IDX_W-1:0] n;
        unique case (mode)
            FM_LINEAR:   n = UOPS_LINEAR;
            FM_AFFINE:   n = UOPS_AFFINE;
            FM_BILINEAR: n = UOPS_BILINEAR;
            FM_NONE:     n = UOPS_NONE;
        endcase
        return n;
    endfunction

    // field products first, the two step products last
    function automatic uop_t uop_at(input field_mode_t mode, input logic [UOP_IDX_W-1:0] idx);
        uop_t                 u;
        logic [UOP_IDX_W-1:0] n;
        n = uop_count(mode);
        u = mk_uop(OPA_DX, OPB_STEP, DST_POS_X);
        if (idx == n - UOP_IDX_W'(1)) begin
            u = mk_uop(OPA_DY, OPB_STEP, DST_POS_Y);
        end else if (idx == n - UOP_IDX_W'(2)) begin
            u = mk_uop(OPA_DX, OPB_STEP, DST_POS_X);
        end else begin
            unique case (mode)
                FM_LINEAR: begin
                    unique case (idx)
                        UOP_IDX_W'(0): u = mk_uop(OPA_X, OPB_COEF1, DST_DX_ADD);
                        UOP_IDX_W'(1): u = mk_uop(OPA_Y, OPB_COEF2, DST_DX_ADD);
                        UOP_IDX_W'(2): u = mk_uop(OPA_X, OPB_COEF3, DST_DY_ADD);
                        default:       u = mk_uop(OPA_Y, OPB_COEF4, DST_DY_ADD);
                    endcase
                end
                FM_AFFINE: begin
                    unique case (idx)
                        UOP_IDX_W'(0): u = mk_uop(OPA_X, OPB_COEF1, DST_DX_ADD);
                        UOP_IDX_W'(1): u = mk_uop(OPA_Y, OPB_COEF2, DST_DX_ADD);
                        UOP_IDX_W'(2): u = mk_uop(OPA_X, OPB_COEF4, DST_DY_ADD);
                        default:       u = mk_uop(OPA_Y, OPB_COEF5, DST_DY_ADD);
                    endcase
                end
                FM_BILINEAR: begin
                    unique case (idx)
                        UOP_IDX_W'(0): u = mk_uop(OPA_X,  OPB_Y,     DST_XY);
                        UOP_IDX_W'(1): u = mk_uop(OPA_XY, OPB_COEF1, DST_DX_ADD);
                        UOP_IDX_W'(2): u = mk_uop(OPA_Y,  OPB_COEF2, DST_DX_ADD);
                        UOP_IDX_W'(3): u = mk_uop(OPA_X,  OPB_COEF3, DST_DX_SUB);
                        UOP_IDX_W'(4): u = mk_uop(OPA_XY, OPB_COEF4, DST_DY_ADD);
                        UOP_IDX_W'(5): u = mk_uop(OPA_X,  OPB_COEF5, DST_DY_ADD);
                        default:       u = mk_uop(OPA_Y,  OPB_COEF6, DST_DY_SUB);
                    endcase
                end
                FM_NONE: begin
                    u = mk_uop(OPA_DX, OPB_STEP, DST_POS_X);
                end
            endcase
        end
        return u;
    endfunction

endpackage

FILE: rtl/epfi_mul.sv
// iterative fixed-point multiplier: 32x32 partial products, round half away, clamp
// depends on epfi_pkg and euler_planar_field_integrator_defines.svh
`include "euler_planar_field_integrator_defines.svh"

module epfi_mul
    import epfi_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [OPD_W-1:0] opd_a,
    input  logic signed [OPD_W-1:0] opd_b,
    output logic                    done,
    output logic                    neg,
    output logic                    sat,
    output logic [MAG_W-1:0]        mag
);

    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    mul_state_t         state_reg, state_next;
    logic [OPD_W-1:0]   a_mag_reg, b_mag_reg;
    logic [OPD_W-1:0]   a_mag_next, b_mag_next;
    logic               a_hi_reg, b_hi_reg;
    logic               neg_reg;
    logic [1:0]         k_reg, k_next;
    logic               k_last;
    logic [PP_W-1:0]    pp_reg;
    logic [1:0]         pp_sh_reg;
    logic               pp_vld_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   pp_wide, acc_sum, quot;
    logic [MAG_W-1:0]   mag_reg;
    logic               sat_reg;
    logic               done_reg;
    logic               issue, finish;
    logic [HALF_W-1:0]  a_half, b_half;

    function automatic logic pp_needed(input logic [1:0] k, input logic ah, input logic bh);
        return (!k[0] || ah) && (!k[1] || bh);
    endfunction

    always_comb begin
        a_mag_next = opd_a[OPD_W-1] ? OPD_W'(-opd_a) : OPD_W'(opd_a);
        b_mag_next = opd_b[OPD_W-1] ? OPD_W'(-opd_b) : OPD_W'(opd_b);
    end

    // next partial product, skipping halves that are zero
    always_comb begin
        k_next = k_reg;
        k_last = 1'b1;
        priority if (k_reg < 2'd1 && pp_needed(2'd1, a_hi_reg, b_hi_reg)) begin
            k_next = 2'd1;
            k_last = 1'b0;
        end else if (k_reg < 2'd2 && pp_needed(2'd2, a_hi_reg, b_hi_reg)) begin
            k_next = 2'd2;
            k_last = 1'b0;
        end else if (k_reg < 2'd3 && pp_needed(2'd3, a_hi_reg, b_hi_reg)) begin
            k_next = 2'd3;
            k_last = 1'b0;
        end
    end

    always_comb begin
        a_half  = k_reg[0] ? a_mag_reg[OPD_W-1:HALF_W] : a_mag_reg[HALF_W-1:0];
        b_half  = k_reg[1] ? b_mag_reg[OPD_W-1:HALF_W] : b_mag_reg[HALF_W-1:0];
        pp_wide = ACC_W'(pp_reg) << (HALF_W * pp_sh_reg);
        acc_sum = acc_reg + pp_wide;
        quot    = acc_sum >> FRAC_BITS;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MS_IDLE: if (start)  state_next = MS_RUN;
            MS_RUN:  if (k_last) state_next = MS_LAST;
            MS_LAST: state_next = MS_IDLE;
            default: state_next = MS_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        issue  = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            MS_IDLE: ;
            MS_RUN:  issue  = 1'b1;
            MS_LAST: finish = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= MS_IDLE;
            k_reg      <= 2'd0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (start && state_reg == MS_IDLE) begin
                k_reg      <= 2'd0;
                pp_vld_reg <= 1'b0;
            end else if (issue) begin
                pp_vld_reg <= 1'b1;
                if (!k_last) begin
                    k_reg <= k_next;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start && state_reg == MS_IDLE) begin
            a_mag_reg <= a_mag_next;
            b_mag_reg <= b_mag_next;
            a_hi_reg  <= |a_mag_next[OPD_W-1:HALF_W];
            b_hi_reg  <= |b_mag_next[OPD_W-1:HALF_W];
            neg_reg   <= opd_a[OPD_W-1] ^ opd_b[OPD_W-1];
            acc_reg   <= ROUND_HALF;
        end
        if (issue) begin
            pp_reg    <= PP_W'(a_half) * PP_W'(b_half);
            pp_sh_reg <= 2'(k_reg[0]) + 2'(k_reg[1]);
            if (pp_vld_reg) begin
                acc_reg <= acc_sum;
            end
        end
        if (finish) begin
            sat_reg <= quot > ACC_W'(LIM_MAG);
            mag_reg <= (quot > ACC_W'(LIM_MAG)) ? LIM_MAG : quot[MAG_W-1:0];
        end
    end

    assign done = done_reg;
    assign neg  = neg_reg;
    assign sat  = sat_reg;
    assign mag  = mag_reg;

    `EPFI_ASSERT_IMPL(a_start_when_idle, clk, rst_n, start, state_reg == MS_IDLE)
    `EPFI_ASSERT_IMPL(a_sat_gives_limit, clk, rst_n, done_reg && sat_reg, mag_reg == LIM_MAG)

endmodule

FILE: rtl/epfi_dp.sv
// datapath: configuration registers, point state, field accumulators, output word
// depends on epfi_pkg and epfi_mul
module epfi_dp
    import epfi_pkg::*;
#(
    parameter int FRAC_BITS = 24,
    parameter int WORD_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [PT_W-1:0]   load_x,
    input  logic signed [PT_W-1:0]   load_y,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    output logic signed [PT_W-1:0]   point_x,
    output logic signed [PT_W-1:0]   point_y,
    output logic                     clipped
);

    localparam logic signed [OPD_W-1:0] W_MAX = (OPD_W'(1) <<< (WORD_BITS - 1)) - OPD_W'(1);
    localparam logic signed [OPD_W-1:0] W_MIN = -W_MAX - OPD_W'(1);

    field_mode_t                mode_reg;
    logic signed [COEF_W-1:0]   coef_reg [COEF_N];
    logic [STEP_W-1:0]          step_reg;
    logic signed [WORD_BITS-1:0] pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic signed [OPD_W-1:0]    xy_reg, dx_reg, dy_reg, xy_next, dx_next, dy_next;
    logic                       sat_reg, sat_next;
    logic [PT_W-1:0]            out_x_reg, out_y_reg;
    logic                       out_clip_reg;
    logic signed [OPD_W-1:0]    x64, y64, lx64, ly64, opd_a, opd_b, mag_s, res, nx, ny;
    logic                       mul_done, mul_neg, mul_sat;
    logic [MAG_W-1:0]           mul_mag;

    function automatic logic word_over(input logic signed [OPD_W-1:0] v);
        return (v > W_MAX) || (v < W_MIN);
    endfunction

    function automatic logic signed [WORD_BITS-1:0] word_clamp(input logic signed [OPD_W-1:0] v);
        logic signed [OPD_W-1:0] c;
        c = v;
        if (v > W_MAX) c = W_MAX;
        if (v < W_MIN) c = W_MIN;
        return c[WORD_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg <= FM_BILINEAR;
            for (int i = 0; i < COEF_N; i++) begin
                coef_reg[i] <= COEF_RESET[i];
            end
            step_reg <= STEP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg    <= field_mode_t'(cfg_data[1:0]);
                CFG_COEF1: coef_reg[0] <= cfg_data;
                CFG_COEF2: coef_reg[1] <= cfg_data;
                CFG_COEF3: coef_reg[2] <= cfg_data;
                CFG_COEF4: coef_reg[3] <= cfg_data;
                CFG_COEF5: coef_reg[4] <= cfg_data;
                CFG_COEF6: coef_reg[5] <= cfg_data;
                CFG_STEP:  step_reg    <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // operand selection
    always_comb begin
        x64 = OPD_W'(pos_x_reg);
        y64 = OPD_W'(pos_y_reg);
        unique case (cmd.uop.a_sel)
            OPA_X:   opd_a = x64;
            OPA_Y:   opd_a = y64;
            OPA_XY:  opd_a = xy_reg;
            OPA_DX:  opd_a = dx_reg;
            OPA_DY:  opd_a = dy_reg;
            default: opd_a = x64;
        endcase
        unique case (cmd.uop.b_sel)
            OPB_COEF1: opd_b = OPD_W'(coef_reg[0]);
            OPB_COEF2: opd_b = OPD_W'(coef_reg[1]);
            OPB_COEF3: opd_b = OPD_W'(coef_reg[2]);
            OPB_COEF4: opd_b = OPD_W'(coef_reg[3]);
            OPB_COEF5: opd_b = OPD_W'(coef_reg[4]);
            OPB_COEF6: opd_b = OPD_W'(coef_reg[5]);
            OPB_STEP:  opd_b = signed'(OPD_W'(step_reg));
            OPB_Y:     opd_b = y64;
        endcase
    end

    epfi_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .opd_a (opd_a),
        .opd_b (opd_b),
        .done  (mul_done),
        .neg   (mul_neg),
        .sat   (mul_sat),
        .mag   (mul_mag)
    );

    always_comb begin
        lx64  = OPD_W'(load_x);
        ly64  = OPD_W'(load_y);
        mag_s = signed'(OPD_W'(mul_mag));
        res   = mul_neg ? -mag_s : mag_s;
        nx    = x64 + res;
        ny    = y64 + res;
    end

    always_comb begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        xy_next    = xy_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sat_next   = sat_reg;
        if (cmd.accept) begin
            sat_next = 1'b0;
            if (cmd.load) begin
                pos_x_next = word_clamp(lx64);
                pos_y_next = word_clamp(ly64);
                sat_next   = word_over(lx64) || word_over(ly64);
            end
        end
        // affine offsets seed the sums
        if (cmd.init) begin
            dx_next = (mode_reg == FM_AFFINE) ? OPD_W'(coef_reg[2]) : '0;
            dy_next = (mode_reg == FM_AFFINE) ? OPD_W'(coef_reg[5]) : '0;
        end
        if (cmd.commit) begin
            sat_next = sat_reg || mul_sat;
            unique case (cmd.uop.dst)
                DST_XY:     xy_next = res;
                DST_DX_ADD: dx_next = dx_reg + res;
                DST_DX_SUB: dx_next = dx_reg - res;
                DST_DY_ADD: dy_next = dy_reg + res;
                DST_DY_SUB: dy_next = dy_reg - res;
                DST_POS_X: begin
                    pos_x_next = word_clamp(nx);
                    sat_next   = sat_reg || mul_sat || word_over(nx);
                end
                DST_POS_Y: begin
                    pos_y_next = word_clamp(ny);
                    sat_next   = sat_reg || mul_sat || word_over(ny);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    always_ff @(posedge clk) begin
        xy_reg  <= xy_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sat_reg <= sat_next;
        if (cmd.out_load) begin
            out_x_reg    <= x64[PT_W-1:0];
            out_y_reg    <= y64[PT_W-1:0];
            out_clip_reg <= sat_reg;
        end
    end

    assign sts.mode     = mode_reg;
    assign sts.mul_done = mul_done;
    assign point_x      = out_x_reg;
    assign point_y      = out_y_reg;
    assign clipped      = out_clip_reg;

endmodule

FILE: rtl/epfi_ctrl.sv
// controller: accepts words, walks the product sequence, hands the result word on
// depends on epfi_pkg and euler_planar_field_integrator_defines.svh
`include "euler_planar_field_integrator_defines.svh"

module epfi_ctrl
    import epfi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic op,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t          state_reg, state_next;
    logic [UOP_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (in_valid) begin
                    state_next = (op == OP_STEP) ? CS_INIT : CS_DONE;
                end
            end
            CS_INIT: begin
                idx_next   = '0;
                state_next = CS_ISSUE;
            end
            CS_ISSUE: state_next = CS_WAIT;
            CS_WAIT: begin
                if (sts.mul_done) begin
                    if (idx_reg == uop_count(sts.mode) - UOP_IDX_W'(1)) begin
                        state_next = CS_DONE;
                    end else begin
                        idx_next   = idx_reg + UOP_IDX_W'(1);
                        state_next = CS_ISSUE;
                    end
                end
            end
            CS_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        cmd.uop  = uop_at(sts.mode, idx_reg);
        in_ready = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                cmd.load   = in_valid && (op == OP_LOAD);
            end
            CS_INIT:  cmd.init      = 1'b1;
            CS_ISSUE: cmd.mul_start = 1'b1;
            CS_WAIT:  cmd.commit    = sts.mul_done;
            CS_DONE:  cmd.out_load  = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        if (cmd.out_load)               out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= CS_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `EPFI_ASSERT_IMPL(a_done_in_wait, clk, rst_n, sts.mul_done, state_reg == CS_WAIT)
    `EPFI_ASSERT_IMPL(a_idx_in_range, clk, rst_n, state_reg == CS_ISSUE, idx_reg < uop_count(sts.mode))
    `EPFI_ASSERT_NEXT(a_wait_holds, clk, rst_n, (state_reg == CS_WAIT) && !sts.mul_done, state_reg == CS_WAIT)

endmodule

FILE: rtl/euler_planar_field_integrator.sv
// load word: accepted, then handed to the output register; step word: sums seeded, then each
// of its products issued to the shared 32x32 multiplier (1..4 partial products, zero halves
// skipped) and committed, then the result handed on; one word in flight at a time
// the shared multiplier and its product sequence set how long a step word takes
// rst_n is asynchronous, active low: clears the point to zero and loads register defaults
// top level of the planar forward Euler field integrator
// depends on epfi_pkg, epfi_ctrl, epfi_dp (and epfi_mul below it)
module euler_planar_field_integrator
    import epfi_pkg::*;
#(
    parameter int FRAC_BITS = 24,
    parameter int WORD_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration writes
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // input words
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    op,
    input  logic signed [PT_W-1:0]  load_x,
    input  logic signed [PT_W-1:0]  load_y,
    // result words
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [PT_W-1:0]  point_x,
    output logic signed [PT_W-1:0]  point_y,
    output logic                    clipped
);

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // controller: idle, accept, sequence products, hand result to output register
    epfi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: registers, point, sums and the iterative multiplier
    // the output register lets a new word be taken while a result waits
    epfi_dp #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .load_x    (load_x),
        .load_y    (load_y),
        .cmd       (cmd),
        .sts       (sts),
        .point_x   (point_x),
        .point_y   (point_y),
        .clipped   (clipped)
    );

endmodule
